@@ hdl/cvm_pkg.sv @@
// Shared types and scaling constants for the current/voltage monitor.
`default_nettype none

package cvm_pkg;

    // Field widths
    localparam int MV_W        = 12;
    localparam int CUR_W       = 13;
    localparam int VOLT_W      = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    // Sample kinds
    localparam logic CMD_CURRENT = 1'b0;
    localparam logic CMD_VOLTAGE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ALARM_ENABLE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALARM_LEVEL   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RECOVER_LEVEL = 2'd2;

    // ADC full scale in millivolts
    localparam logic [MV_W-1:0] MV_SCALE = 12'd3300;

    // mv*40/21 and mv*21/1000 as one multiply by a folded reciprocal.
    // mv*40 stays below 2^18 and mv*21 below 2^17; the ceil reciprocals carry
    // errors of 5 and 272, small enough that the floor is exact over those ranges.
    localparam int CUR_NUM    = 40;
    localparam int CUR_DEN    = 21;
    localparam int CUR_SHIFT  = 22;
    localparam int VOLT_NUM   = 21;
    localparam int VOLT_DEN   = 1000;
    localparam int VOLT_SHIFT = 27;
    localparam int SCALE_W    = 23;
    localparam int PROD_W     = MV_W + SCALE_W;

    localparam logic [SCALE_W-1:0] CUR_MUL =
        SCALE_W'(CUR_NUM * (((1 << CUR_SHIFT) + CUR_DEN - 1) / CUR_DEN));
    localparam logic [SCALE_W-1:0] VOLT_MUL =
        SCALE_W'(VOLT_NUM * (((1 << VOLT_SHIFT) + VOLT_DEN - 1) / VOLT_DEN));

    // Zero offset of the current sensor, in mA
    localparam logic [CUR_W-1:0] CUR_OFFSET = 13'd80;

    typedef struct packed {
        logic              alarm_enable;
        logic [CUR_W-1:0]  alarm_level;
        logic [CUR_W-1:0]  recover_level;
    } cvm_cfg_t;

    // Item handed from the averaging stage to the output stage
    typedef struct packed {
        logic              load;
        logic              cmd;
        logic [CUR_W-1:0]  avg;
        logic [VOLT_W-1:0] volt;
    } cvm_stage_t;

endpackage

`default_nettype wire

@@ hdl/cvm_cell.sv @@
// One cell of the current sample window: holds a sample, passes it on shift.
`default_nettype none

module cvm_cell (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     shift_en,
    input  wire logic [cvm_pkg::CUR_W-1:0] d,
    output logic      [cvm_pkg::CUR_W-1:0] q
);
    import cvm_pkg::*;

    logic [CUR_W-1:0] data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else if (shift_en)
        begin
            data_reg <= d;
        end
    end

    assign q = data_reg;

endmodule

`default_nettype wire

@@ hdl/cvm_window.sv @@
// Row of window cells with a running sum of their contents.
`default_nettype none

module cvm_window #(
    parameter int DEPTH = 3
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          shift_en,
    input  wire logic [cvm_pkg::CUR_W-1:0]                      sample,
    output logic      [cvm_pkg::CUR_W+$clog2(DEPTH)-1:0]        sum
);
    import cvm_pkg::*;

    localparam int SumW = CUR_W + $clog2(DEPTH);

    logic [CUR_W-1:0] tap [DEPTH];
    logic [SumW-1:0]  sum_reg;
    logic [SumW-1:0]  sum_next;
    logic [SumW:0]    sum_calc;

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                cvm_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (shift_en),
                    .d        (sample),
                    .q        (tap[k])
                );
            end
            else
            begin : g_body
                cvm_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (shift_en),
                    .d        (tap[k-1]),
                    .q        (tap[k])
                );
            end
        end
    endgenerate

    // new sample enters, the oldest one drops off the end of the row
    assign sum_calc = {1'b0, sum_reg} + (SumW+1)'(sample) - (SumW+1)'(tap[DEPTH-1]);
    assign sum_next = sum_calc[SumW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (shift_en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire

@@ hdl/cvm_alarm.sv @@
// Output stage: offset correction, hysteresis alarm and held readings.
`default_nettype none

module cvm_alarm (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire cvm_pkg::cvm_cfg_t           cfg,
    input  wire cvm_pkg::cvm_stage_t         stage,
    output logic      [cvm_pkg::CUR_W-1:0]   current_ma,
    output logic      [cvm_pkg::VOLT_W-1:0]  voltage_v,
    output logic                             alarm
);
    import cvm_pkg::*;

    logic [CUR_W-1:0]  cur_reg;
    logic [CUR_W-1:0]  cur_next;
    logic [VOLT_W-1:0] volt_reg;
    logic [VOLT_W-1:0] volt_next;
    logic              alarm_reg;
    logic              alarm_next;
    logic [CUR_W-1:0]  avg_adj;

    assign avg_adj = (stage.avg > CUR_OFFSET) ? (stage.avg - CUR_OFFSET) : stage.avg;

    always_comb
    begin
        cur_next   = cur_reg;
        volt_next  = volt_reg;
        alarm_next = alarm_reg;
        if (stage.load)
        begin
            if (stage.cmd == CMD_CURRENT)
            begin
                cur_next = avg_adj;
                if (cfg.alarm_enable)
                begin
                    priority if (avg_adj > cfg.alarm_level)
                    begin
                        alarm_next = 1'b1;
                    end
                    else if (avg_adj < cfg.recover_level)
                    begin
                        alarm_next = 1'b0;
                    end
                    else
                    begin
                        alarm_next = alarm_reg;
                    end
                end
            end
            else
            begin
                volt_next = stage.volt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg   <= '0;
            volt_reg  <= '0;
            alarm_reg <= 1'b0;
        end
        else
        begin
            cur_reg   <= cur_next;
            volt_reg  <= volt_next;
            alarm_reg <= alarm_next;
        end
    end

    assign current_ma = cur_reg;
    assign voltage_v  = volt_reg;
    assign alarm      = alarm_reg;

endmodule

`default_nettype wire

@@ hdl/current_voltage_monitor_alarm.sv @@
// Top level of the current/voltage monitor with averaged current and alarm.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------
//  in      | sink      | in_valid / in_stall    | cmd, raw_sample
//  out     | source    | out_valid / out_stall  | current_ma, voltage_v, alarm
//  cfg     | sink      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  One transaction per cycle in and out while out_stall is low. Stages from input
//  acceptance to out_valid: ADC scale, current/voltage scale (one shared
//  multiplier), window shift, divide by window depth, offset and alarm.
//  Each stage holds its item while the next one is full, so a stalled output
//  lets up to four more transactions enter before in_stall rises.
//  Reset clears the window, the held readings, the alarm, the configuration registers
//  and the stage valid flags. cfg_ready is always high.
`default_nettype none

module current_voltage_monitor_alarm #(
    parameter int WINDOW_DEPTH = 3,
    parameter int ADC_BITS     = 12
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              cmd,
    input  wire logic [ADC_BITS-1:0]               raw_sample,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [cvm_pkg::CUR_W-1:0]         current_ma,
    output logic      [cvm_pkg::VOLT_W-1:0]        voltage_v,
    output logic                                   alarm,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [cvm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [cvm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import cvm_pkg::*;

    localparam int DivL = $clog2(WINDOW_DEPTH);
    localparam int SumW = CUR_W + DivL;
    localparam int DivS = SumW + DivL;
    localparam int DivM = ((1 << DivS) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
    localparam logic [SumW:0] DivMul = (SumW+1)'(DivM);
    localparam int AdcW = ADC_BITS + MV_W;

    cvm_cfg_t cfg_reg;

    logic              s1_valid_reg;
    logic              s1_cmd_reg;
    logic [MV_W-1:0]   s1_mv_reg;
    logic              s2_valid_reg;
    logic              s2_cmd_reg;
    logic [CUR_W-1:0]  s2_ma_reg;
    logic [VOLT_W-1:0] s2_volt_reg;
    logic              s3_valid_reg;
    logic              s3_cmd_reg;
    logic [VOLT_W-1:0] s3_volt_reg;
    logic              s4_valid_reg;
    logic              s4_cmd_reg;
    logic [CUR_W-1:0]  s4_avg_reg;
    logic [VOLT_W-1:0] s4_volt_reg;
    logic              out_valid_reg;

    logic              out_free;
    logic              s4_free;
    logic              s3_free;
    logic              s2_free;
    logic              s1_free;
    logic              s4_move;
    logic              s3_move;
    logic              s2_move;
    logic              s1_move;

    logic [AdcW-1:0]    adc_prod;
    logic [SCALE_W-1:0] scale_mul;
    logic [PROD_W-1:0]  scale_prod;
    logic [SumW-1:0]    win_sum;
    logic [2*SumW:0]    div_prod;
    cvm_stage_t         out_stage;

    // Stage moves when it holds an item and the one after it is free
    assign out_free = !out_valid_reg || !out_stall;
    assign s4_move  = s4_valid_reg && out_free;
    assign s4_free  = !s4_valid_reg || s4_move;
    assign s3_move  = s3_valid_reg && s4_free;
    assign s3_free  = !s3_valid_reg || s3_move;
    assign s2_move  = s2_valid_reg && s3_free;
    assign s2_free  = !s2_valid_reg || s2_move;
    assign s1_move  = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s1_move;

    assign in_stall  = !s1_free;
    assign out_valid = out_valid_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ALARM_ENABLE:  cfg_reg.alarm_enable  <= cfg_data[0];
                CFG_ALARM_LEVEL:   cfg_reg.alarm_level   <= cfg_data;
                CFG_RECOVER_LEVEL: cfg_reg.recover_level <= cfg_data;
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // raw * 3300 >> ADC_BITS always stays below 3300
    assign adc_prod = AdcW'(raw_sample) * AdcW'(MV_SCALE);

    assign scale_mul  = (s1_cmd_reg == CMD_CURRENT) ? CUR_MUL : VOLT_MUL;
    assign scale_prod = PROD_W'(s1_mv_reg) * PROD_W'(scale_mul);

    assign div_prod = (2*SumW+1)'(win_sum) * (2*SumW+1)'(DivMul);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_free)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free)
        begin
            s1_cmd_reg <= cmd;
            s1_mv_reg  <= adc_prod[ADC_BITS +: MV_W];
        end
        if (s2_free)
        begin
            s2_cmd_reg  <= s1_cmd_reg;
            s2_ma_reg   <= scale_prod[CUR_SHIFT +: CUR_W];
            s2_volt_reg <= scale_prod[VOLT_SHIFT +: VOLT_W];
        end
        if (s3_free)
        begin
            s3_cmd_reg  <= s2_cmd_reg;
            s3_volt_reg <= s2_volt_reg;
        end
        if (s4_free)
        begin
            s4_cmd_reg  <= s3_cmd_reg;
            s4_avg_reg  <= div_prod[DivS +: CUR_W];
            s4_volt_reg <= s3_volt_reg;
        end
    end

    // window and its sum update as a current transaction enters stage 3
    cvm_window #(
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (s2_move && (s2_cmd_reg == CMD_CURRENT)),
        .sample   (s2_ma_reg),
        .sum      (win_sum)
    );

    assign out_stage.load = s4_move;
    assign out_stage.cmd  = s4_cmd_reg;
    assign out_stage.avg  = s4_avg_reg;
    assign out_stage.volt = s4_volt_reg;

    cvm_alarm u_alarm (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .stage      (out_stage),
        .current_ma (current_ma),
        .voltage_v  (voltage_v),
        .alarm      (alarm)
    );

endmodule

`default_nettype wire

@@ hdl/cvm_checker.sv @@
// Port-level checks for the current/voltage monitor, bound to the top level.
`default_nettype none

module cvm_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire logic [cvm_pkg::CUR_W-1:0]         current_ma,
    input wire logic [cvm_pkg::VOLT_W-1:0]        voltage_v,
    input wire logic                              alarm
);
    import cvm_pkg::*;

    logic [CUR_W-1:0]  prev_cur_reg;
    logic [VOLT_W-1:0] prev_volt_reg;
    logic              prev_alarm_reg;
    logic              out_xfer;

    assign out_xfer = out_valid && !out_stall;

    // readings of the last delivered transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_cur_reg   <= '0;
            prev_volt_reg  <= '0;
            prev_alarm_reg <= 1'b0;
        end
        else if (out_xfer)
        begin
            prev_cur_reg   <= current_ma;
            prev_volt_reg  <= voltage_v;
            prev_alarm_reg <= alarm;
        end
    end

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(current_ma)
            && $stable(voltage_v) && $stable(alarm))
        else $error("stalled result changed");

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> current_ma <= 13'd6283 && voltage_v <= 7'd69)
        else $error("result outside scaled range");

    // a transaction updates either the current side or the voltage side
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer |-> voltage_v == prev_volt_reg
            || (current_ma == prev_cur_reg && alarm == prev_alarm_reg))
        else $error("current and voltage changed in one transaction");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid && alarm == 1'b0 && current_ma == '0)
        else $error("state not cleared by reset");

endmodule

bind current_voltage_monitor_alarm cvm_checker u_checker (.*);

`default_nettype wire

@@ tb/current_voltage_monitor_alarm_test.sv @@
// Testbench for the current/voltage monitor: directed and random samples against a predictor.
`timescale 1ns / 1ps

module current_voltage_monitor_alarm_test;

    import cvm_pkg::*;

    localparam int ADC_W      = 12;
    localparam int DEPTH      = 3;
    localparam int SLOT_W     = $clog2(DEPTH);
    localparam int MV_FULL    = 3300;
    localparam int LATENCY    = 5;
    localparam int CYCLE_CAP  = 200000;
    localparam int PHASES     = 10;
    localparam int PHASE_SIZE = 55;

    // Index outside the register map; the block ignores writes to it
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [CUR_W-1:0]  current_ma;
        logic [VOLT_W-1:0] voltage_v;
        logic              alarm;
    } reading_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic                   cmd;
    logic [ADC_W-1:0]       raw_sample;
    logic                   out_valid;
    logic                   out_stall;
    logic [CUR_W-1:0]       current_ma;
    logic [VOLT_W-1:0]      voltage_v;
    logic                   alarm;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Predictor state
    logic [CUR_W-1:0]  window_ma [DEPTH];
    logic [SLOT_W-1:0] slot;
    logic              alarm_flag;
    logic [CUR_W-1:0]  held_current;
    logic [VOLT_W-1:0] held_voltage;
    logic              cfg_alarm_enable;
    logic [CUR_W-1:0]  cfg_alarm_level;
    logic [CUR_W-1:0]  cfg_recover_level;

    reading_t expected_readings[$];
    int       mismatch_count;
    int       cycle_count;
    logic     tx_idle;
    logic     rx_idle;
    int       rx_hold;

    current_voltage_monitor_alarm #(
        .WINDOW_DEPTH(DEPTH),
        .ADC_BITS(ADC_W)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .raw_sample(raw_sample),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .current_ma(current_ma),
        .voltage_v(voltage_v),
        .alarm(alarm),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_CAP)
            begin
                $display("current_voltage_monitor_alarm: mismatch");
                $finish;
            end
        end
    end

    // Advances the predictor by one accepted sample and returns the reading it implies
    function automatic reading_t predict_reading(logic kind, logic [ADC_W-1:0] raw);
        int unsigned mv;
        int unsigned ma;
        int unsigned sum;
        int unsigned avg;
        reading_t    r;
        mv = (int'(raw) * MV_FULL) >> ADC_W;
        if (kind == CMD_CURRENT)
        begin
            ma = mv * CUR_NUM / CUR_DEN;
            window_ma[slot] = CUR_W'(ma);
            slot = (slot == SLOT_W'(DEPTH - 1)) ? '0 : slot + 1'b1;
            sum = 0;
            for (int k = 0; k < DEPTH; k++)
                sum += window_ma[k];
            avg = sum / DEPTH;
            if (avg > CUR_OFFSET)
                avg -= CUR_OFFSET;
            held_current = CUR_W'(avg);
            if (cfg_alarm_enable)
            begin
                if (held_current > cfg_alarm_level)
                    alarm_flag = 1'b1;
                else if (held_current < cfg_recover_level)
                    alarm_flag = 1'b0;
            end
        end
        else
        begin
            held_voltage = VOLT_W'(mv * VOLT_NUM / VOLT_DEN);
        end
        r.current_ma = held_current;
        r.voltage_v  = held_voltage;
        r.alarm      = alarm_flag;
        return r;
    endfunction

    task automatic send_sample(logic kind, logic [ADC_W-1:0] raw);
        int gap;
        gap = tx_idle ? $urandom_range(0, 3) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   = 1'b1;
        cmd        = kind;
        raw_sample = raw;
        do
            @(posedge clk);
        while (in_stall);
        expected_readings.push_back(predict_reading(kind, raw));
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_ALARM_ENABLE:  cfg_alarm_enable  = data[0];
            CFG_ALARM_LEVEL:   cfg_alarm_level   = data;
            CFG_RECOVER_LEVEL: cfg_recover_level = data;
            default:           ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 3) @(posedge clk);
    endtask

    task automatic check_reading();
        reading_t want;
        reading_t seen;
        seen.current_ma = current_ma;
        seen.voltage_v  = voltage_v;
        seen.alarm      = alarm;
        if (expected_readings.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected transaction: current %0d voltage %0d alarm %0d",
                         seen.current_ma, seen.voltage_v, seen.alarm);
        end
        else
        begin
            want = expected_readings.pop_front();
            if (seen.current_ma !== want.current_ma || seen.voltage_v !== want.voltage_v ||
                seen.alarm !== want.alarm)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("reading differs: current %0d/%0d voltage %0d/%0d alarm %0d/%0d",
                             want.current_ma, seen.current_ma, want.voltage_v, seen.voltage_v,
                             want.alarm, seen.alarm);
            end
        end
    endtask

    // Result checking at the rising edge; receiver back-pressure at the falling edge,
    // asserted for a randomly drawn hold after each transaction while rx_idle is set
    initial
    begin
        mismatch_count = 0;
        out_stall      = 1'b0;
        rx_hold        = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                check_reading();
                rx_hold = rx_idle ? $urandom_range(0, 3) : 0;
            end
            @(negedge clk);
            if (rx_hold > 0)
            begin
                out_stall = 1'b1;
                rx_hold--;
            end
            else
                out_stall = 1'b0;
        end
    end

    // Ring starts at zero; alarm is off after reset no matter the current
    task automatic test_warm_up();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        repeat (3) send_sample(CMD_CURRENT, 12'hFFF);
        send_sample(CMD_VOLTAGE, 12'hFFF);
        send_sample(CMD_VOLTAGE, 12'h000);
        send_sample(CMD_CURRENT, 12'h000);
    endtask

    // Averages landing at, and just above, the sensor offset
    task automatic test_offset_boundary();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        repeat (2) send_sample(CMD_CURRENT, 12'd0);
        repeat (3) send_sample(CMD_CURRENT, 12'd53);
        repeat (3) send_sample(CMD_CURRENT, 12'd54);
    endtask

    task automatic test_alarm_hysteresis();
        wait_drained();
        write_register(CFG_ALARM_LEVEL, 13'd2000);
        write_register(CFG_RECOVER_LEVEL, 13'd1000);
        write_register(CFG_ALARM_ENABLE, 13'd1);
        send_sample(CMD_CURRENT, 12'hFFF);
        // settles between the levels, alarm must hold
        repeat (3) send_sample(CMD_CURRENT, 12'd978);
        repeat (2) send_sample(CMD_CURRENT, 12'd0);
        wait_drained();
        // bit 0 clears the enable; upper bits are don't-care
        write_register(CFG_ALARM_ENABLE, 13'h1FFE);
        write_register(CFG_UNMAPPED, 13'h1FFF);
        send_sample(CMD_CURRENT, 12'hFFF);
    endtask

    task automatic test_random_traffic();
        int               base;
        logic [CUR_W-1:0] level;
        logic [CUR_W-1:0] recover;
        logic             kind;
        logic [ADC_W-1:0] raw;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_drained();
            if (phase == 0)
            begin
                level   = '0;
                recover = '0;
            end
            else if (phase == 1)
            begin
                level   = '1;
                recover = '1;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                level   = CUR_W'($urandom_range(0, 8191));
                recover = CUR_W'($urandom_range(0, 8191));
            end
            else
            begin
                level   = CUR_W'($urandom_range(0, 6400));
                recover = CUR_W'($urandom_range(0, level));
            end
            write_register(CFG_ALARM_LEVEL, level);
            write_register(CFG_RECOVER_LEVEL, recover);
            write_register(CFG_ALARM_ENABLE,
                           {12'($urandom), (phase < 2) || ($urandom_range(0, 3) != 0)});
            tx_idle = (phase % 3) != 0;
            rx_idle = (phase % 4) != 1;
            base = $urandom_range(0, 4095);
            for (int n = 0; n < PHASE_SIZE; n++)
            begin
                kind = ($urandom_range(0, 3) == 0) ? CMD_VOLTAGE : CMD_CURRENT;
                if (phase % 2 == 1)
                begin
                    // slow drift so the average wanders across the alarm levels
                    base = base + $urandom_range(0, 400) - 200;
                    if (base < 0)
                        base = 0;
                    if (base > 4095)
                        base = 4095;
                    raw = ADC_W'(base);
                end
                else if ($urandom_range(0, 9) == 0)
                    raw = $urandom_range(0, 1) ? '1 : '0;
                else
                    raw = ADC_W'($urandom_range(0, 4095));
                send_sample(kind, raw);
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        cmd        = CMD_CURRENT;
        raw_sample = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_ALARM_ENABLE;
        cfg_data   = '0;
        tx_idle    = 1'b0;
        rx_idle    = 1'b0;
        for (int k = 0; k < DEPTH; k++)
            window_ma[k] = '0;
        slot              = '0;
        alarm_flag        = 1'b0;
        held_current      = '0;
        held_voltage      = '0;
        cfg_alarm_enable  = 1'b0;
        cfg_alarm_level   = '0;
        cfg_recover_level = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_warm_up();
        test_offset_boundary();
        test_alarm_hysteresis();
        test_random_traffic();
        wait_drained();

        if (mismatch_count == 0 && expected_readings.size() == 0)
            $display("current_voltage_monitor_alarm: match");
        else
            $display("current_voltage_monitor_alarm: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/cvm_pkg.sv
hdl/cvm_cell.sv
hdl/cvm_window.sv
hdl/cvm_alarm.sv
hdl/current_voltage_monitor_alarm.sv
hdl/cvm_checker.sv
tb/current_voltage_monitor_alarm_test.sv
